### hw/rtl/scp_pkg.sv
// Package for the serpentine cell placer: coordinate widths, zone constants,
// register indexes, controller states and the controller/datapath interface.
// No dependencies.
`default_nettype none

package scp_pkg;

	localparam int DIM_W   = 9;
	localparam int COL_W   = 10;
	localparam int COORD_W = 11;
	localparam int SYM_W   = 2;
	localparam int OUT_W   = 8;

	localparam logic [DIM_W-1:0] ROWS_RESET = 9'd108;
	localparam logic [DIM_W-1:0] COLS_RESET = 9'd192;

	localparam logic signed [COORD_W-1:0] CORNER_LAST = 11'sd7;
	localparam logic signed [COORD_W-1:0] CORNER_SIZE = 11'sd8;
	localparam logic signed [COORD_W-1:0] CORNER_SKIP = 11'sd9;
	localparam logic signed [COORD_W-1:0] ALIGN_FAR   = 11'sd6;
	localparam logic signed [COORD_W-1:0] ALIGN_NEAR  = 11'sd2;
	localparam logic signed [COORD_W-1:0] ALIGN_SKIP  = 11'sd7;
	localparam logic signed [COORD_W-1:0] ONE_S       = 11'sd1;
	localparam logic signed [COORD_W-1:0] MINUS_ONE_S = -11'sd1;

	typedef enum logic [0:0] {
		REG_GRID_ROWS = 1'b0,
		REG_GRID_COLS = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_WALK
	} state_t;

	typedef enum logic [1:0] {
		KIND_FULL,
		KIND_FREE,
		KIND_SKIP,
		KIND_ROW
	} cell_kind_t;

	typedef struct packed {
		logic load;
		logic step;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		cell_kind_t kind;
		logic       slot_free;
	} dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/scp_ctrl.sv
// Controller state machine of the serpentine cell placer.
// Depends on scp_pkg; drives the datapath through command and status structs.
`default_nettype none

module scp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire scp_pkg::dp_status_t status,
	output scp_pkg::dp_cmd_t         cmd
);
	import scp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_WALK;
				end
			end
			ST_WALK: begin
				case (status.kind) inside
					KIND_FULL, KIND_FREE: begin
						if (status.slot_free) begin
							cmd.step = 1'b1;
							cmd.emit = 1'b1;
							state_d  = ST_IDLE;
						end
					end
					default: begin
						cmd.step = 1'b1;
					end
				endcase
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.slot_free && state_q == ST_WALK)
		else $error("result written while the output register is occupied");
	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_WALK)
		else $error("accepted request did not start a walk");
	a_emit_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == ST_IDLE && in_ready)
		else $error("controller did not return to idle after a result");
`endif

endmodule

`default_nettype wire

### hw/rtl/scp_datapath.sv
// Datapath of the serpentine cell placer: grid registers, walk position,
// reserved-zone jump logic and the output register. Depends on scp_pkg.
`default_nettype none

module scp_datapath #(
	parameter int MAX_DIM = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	input  wire scp_pkg::cfg_reg_t           cfg_index,
	input  wire logic [scp_pkg::DIM_W-1:0]   cfg_data,
	input  wire logic                        start_frame,
	input  wire logic [scp_pkg::SYM_W-1:0]   symbol,
	input  wire scp_pkg::dp_cmd_t            cmd,
	output scp_pkg::dp_status_t              status,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             placed,
	output logic [scp_pkg::OUT_W-1:0]        cell_row,
	output logic [scp_pkg::OUT_W-1:0]        cell_col,
	output logic [scp_pkg::SYM_W-1:0]        cell_symbol
);
	import scp_pkg::*;

	localparam int unsigned DIM_MAX = (1 << DIM_W) - 1;
	localparam int unsigned SAT = (MAX_DIM > DIM_MAX) ? DIM_MAX : MAX_DIM;

	logic [DIM_W-1:0]          rows_q;
	logic [DIM_W-1:0]          cols_q;
	logic [DIM_W-1:0]          pos_row_q;
	logic signed [COL_W-1:0]   pos_col_q;
	logic [SYM_W-1:0]          symbol_q;
	logic                      out_valid_q;
	logic                      placed_q;
	logic [OUT_W-1:0]          cell_row_q;
	logic [OUT_W-1:0]          cell_col_q;
	logic [SYM_W-1:0]          cell_symbol_q;

	logic [DIM_W-1:0]          r_dim;
	logic [DIM_W-1:0]          c_dim;
	logic signed [COORD_W-1:0] rr;
	logic signed [COORD_W-1:0] cc;
	logic signed [COORD_W-1:0] r_s;
	logic signed [COORD_W-1:0] c_s;
	logic                      even;
	logic                      full;
	logic                      col_in;
	logic                      top;
	logic                      low;
	logic                      c_lo;
	logic                      c_hi;
	logic                      align;
	logic                      rsvd;
	cell_kind_t                kind;
	logic signed [COORD_W-1:0] target;
	logic signed [COORD_W-1:0] jump;
	logic signed [COORD_W-1:0] col_next;
	logic [DIM_W-1:0]          row_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_GRID_ROWS: rows_q <= cfg_data;
				REG_GRID_COLS: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign r_dim = (rows_q > DIM_W'(SAT)) ? DIM_W'(SAT) : rows_q;
	assign c_dim = (cols_q > DIM_W'(SAT)) ? DIM_W'(SAT) : cols_q;
	assign rr    = signed'({2'b00, r_dim});
	assign cc    = signed'({2'b00, c_dim});
	assign r_s   = signed'({2'b00, pos_row_q});
	assign c_s   = {pos_col_q[COL_W-1], pos_col_q};
	assign even  = ~pos_row_q[0];

	assign full   = pos_row_q >= r_dim;
	assign col_in = (c_s >= 11'sd0) && (c_s < cc);
	assign top    = r_s <= CORNER_LAST;
	assign low    = r_s >= rr - CORNER_SIZE;
	assign c_lo   = c_s <= CORNER_LAST;
	assign c_hi   = c_s >= cc - CORNER_SIZE;
	assign align  = (r_s >= rr - ALIGN_FAR) && (r_s <= rr - ALIGN_NEAR)
		&& (c_s >= cc - ALIGN_FAR) && (c_s <= cc - ALIGN_NEAR);
	assign rsvd   = top ? (c_lo || c_hi) : (low && (c_lo || align));

	always_comb begin
		if (full) begin
			kind = KIND_FULL;
		end else if (!col_in) begin
			kind = KIND_ROW;
		end else if (rsvd) begin
			kind = KIND_SKIP;
		end else begin
			kind = KIND_FREE;
		end
	end

	// A reserved run is passed in one jump to the first column beyond it.
	always_comb begin
		if (even) begin
			if (top) begin
				target = c_hi ? cc : CORNER_SIZE;
			end else begin
				target = c_lo ? CORNER_SIZE : cc - ONE_S;
			end
		end else begin
			if (top) begin
				target = c_lo ? MINUS_ONE_S : cc - CORNER_SKIP;
			end else begin
				target = c_lo ? MINUS_ONE_S : cc - ALIGN_SKIP;
			end
		end
		if (target > cc) begin
			jump = cc;
		end else if (target < MINUS_ONE_S) begin
			jump = MINUS_ONE_S;
		end else begin
			jump = target;
		end
	end

	always_comb begin
		col_next = c_s;
		row_next = pos_row_q;
		case (kind)
			KIND_FREE: col_next = even ? c_s + ONE_S : c_s - ONE_S;
			KIND_SKIP: col_next = jump;
			KIND_ROW: begin
				col_next = even ? c_s - ONE_S : c_s + ONE_S;
				row_next = pos_row_q + DIM_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_row_q <= '0;
			pos_col_q <= '0;
		end else if (cmd.load) begin
			if (start_frame) begin
				pos_row_q <= '0;
				pos_col_q <= '0;
			end
		end else if (cmd.step) begin
			pos_row_q <= row_next;
			pos_col_q <= col_next[COL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			symbol_q <= symbol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (kind == KIND_FREE) begin
				placed_q      <= 1'b1;
				cell_row_q    <= pos_row_q[OUT_W-1:0];
				cell_col_q    <= pos_col_q[OUT_W-1:0];
				cell_symbol_q <= symbol_q;
			end else begin
				placed_q      <= 1'b0;
				cell_row_q    <= '0;
				cell_col_q    <= '0;
				cell_symbol_q <= '0;
			end
		end
	end

	assign status.kind      = kind;
	assign status.slot_free = !out_valid_q || out_ready;
	assign out_valid        = out_valid_q;
	assign placed           = placed_q;
	assign cell_row         = cell_row_q;
	assign cell_col         = cell_col_q;
	assign cell_symbol      = cell_symbol_q;

`ifndef SYNTHESIS
	a_col_lower_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_col_q >= -10'sd1)
		else $error("walk column fell below minus one");
	a_skip_keeps_row: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && !cmd.load && kind == KIND_SKIP |=> pos_row_q == $past(pos_row_q))
		else $error("zone jump changed the row");
	a_free_gives_placed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && kind == KIND_FREE |=> out_valid && placed)
		else $error("free cell did not produce a placed result");
`endif

endmodule

`default_nettype wire

### hw/rtl/serpentine_cell_placer_top.sv
// Serpentine cell placer: each request gets one result with the row and column
// of the next free grid cell in serpentine order, reserved zones skipped.
// Input requests arrive on in_valid/in_ready with start_frame and symbol; one
// result per request leaves on out_valid/out_ready with placed, cell_row,
// cell_col and cell_symbol. Grid size is set on the cfg port (index 0 rows,
// index 1 columns), which the user must do only while the block is idle; the
// block itself does not enforce it. cfg_ready is always high. A request is
// accepted in the idle state, then the walk goes one step at a time: a free
// cell, a reserved zone (passed in one jump) or a row change. If the grid is
// full, the result has placed low. The walk is done by one position register
// pair updated once per cycle whenever the controller state machine steps it.
// The result sits in an output register, so a new request is accepted while it
// waits. If the receiver stalls, the walk holds at the found cell until the
// output register frees up. After reset the grid is 108 by 192 and the walk
// stands at row 0, column 0; no result is pending.
`default_nettype none

module serpentine_cell_placer_top #(
	parameter int MAX_DIM = 256
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic                      cfg_index,
	input  wire logic [scp_pkg::DIM_W-1:0] cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      start_frame,
	input  wire logic [scp_pkg::SYM_W-1:0] symbol,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           placed,
	output logic [scp_pkg::OUT_W-1:0]      cell_row,
	output logic [scp_pkg::OUT_W-1:0]      cell_col,
	output logic [scp_pkg::SYM_W-1:0]      cell_symbol
);
	import scp_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	scp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	scp_datapath #(
		.MAX_DIM (MAX_DIM)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_reg_t'(cfg_index)),
		.cfg_data    (cfg_data),
		.start_frame (start_frame),
		.symbol      (symbol),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.placed      (placed),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.cell_symbol (cell_symbol)
	);

endmodule

`default_nettype wire

### tb/sv/serpentine_cell_placer_top_tb.sv
// Self-checking testbench for serpentine_cell_placer_top: random and directed requests
// against a cell-walk predictor, with random gaps, receiver stalls and grid changes.
// Depends on scp_pkg and the placer RTL only.
module serpentine_cell_placer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scp_pkg::*;

	localparam int GRID_MAX     = 256;
	localparam int TARGET_ITEMS = 1100;
	localparam int STALL_LIMIT  = 5000;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 4;

	typedef struct packed {
		logic             placed;
		logic [OUT_W-1:0] row;
		logic [OUT_W-1:0] col;
		logic [SYM_W-1:0] sym;
	} cell_result_t;

	class placement_checker;
		logic [DIM_W-1:0]        rows_reg;
		logic [DIM_W-1:0]        cols_reg;
		logic [DIM_W-1:0]        walk_row;
		logic signed [COL_W-1:0] walk_col;
		cell_result_t            expected_cells[$];
		int                      mismatches;
		int                      placed_seen;
		int                      full_seen;

		function new();
			rows_reg = ROWS_RESET;
			cols_reg = COLS_RESET;
			walk_row = '0;
			walk_col = '0;
			mismatches = 0;
			placed_seen = 0;
			full_seen = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [DIM_W-1:0] value);
			case (idx)
				REG_GRID_ROWS: rows_reg = value;
				REG_GRID_COLS: cols_reg = value;
				default: ;
			endcase
		endfunction

		function bit is_reserved(int r, int c, int nrows, int ncols);
			if (r <= CORNER_LAST)
				return c <= CORNER_LAST || c >= ncols - CORNER_SIZE;
			if (r < nrows - CORNER_SIZE)
				return 1'b0;
			if (r <= nrows - 1 && c <= CORNER_LAST)
				return 1'b1;
			return r >= nrows - ALIGN_FAR && r <= nrows - ALIGN_NEAR &&
				c >= ncols - ALIGN_FAR && c <= ncols - ALIGN_NEAR;
		endfunction

		function cell_result_t next_free_cell(logic sf, logic [SYM_W-1:0] sym);
			int nrows;
			int ncols;
			int r;
			int c;
			int here;
			bit even;
			cell_result_t res;
			nrows = (rows_reg > GRID_MAX) ? GRID_MAX : int'(rows_reg);
			ncols = (cols_reg > GRID_MAX) ? GRID_MAX : int'(cols_reg);
			if (sf) begin
				walk_row = '0;
				walk_col = '0;
			end
			res = '0;
			r = int'(walk_row);
			c = int'(walk_col);
			while (r < nrows) begin
				even = (r % 2) == 0;
				while (c < ncols && c >= 0) begin
					here = c;
					c += even ? 1 : -1;
					if (!is_reserved(r, here, nrows, ncols)) begin
						res.placed = 1'b1;
						res.row = r[OUT_W-1:0];
						res.col = here[OUT_W-1:0];
						res.sym = sym;
						walk_row = r[DIM_W-1:0];
						walk_col = c[COL_W-1:0];
						return res;
					end
				end
				c += even ? -1 : 1;
				r++;
			end
			walk_row = r[DIM_W-1:0];
			walk_col = c[COL_W-1:0];
			return res;
		endfunction

		function void note_request(logic sf, logic [SYM_W-1:0] sym);
			cell_result_t want;
			want = next_free_cell(sf, sym);
			expected_cells = {expected_cells, want};
		endfunction

		function void check_result(cell_result_t got);
			cell_result_t want;
			if (expected_cells.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no request pending: ", $time,
						"placed=%0b row=%0d col=%0d sym=%0d",
						got.placed, got.row, got.col, got.sym);
				return;
			end
			want = expected_cells.pop_front();
			if (want.placed)
				placed_seen++;
			else
				full_seen++;
			if (got.placed !== want.placed || got.row !== want.row ||
					got.col !== want.col || got.sym !== want.sym) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch: ", $time,
						"expected placed=%0b row=%0d col=%0d sym=%0d, ",
						want.placed, want.row, want.col, want.sym,
						"got placed=%0b row=%0d col=%0d sym=%0d",
						got.placed, got.row, got.col, got.sym);
			end
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic             cfg_index;
	logic [DIM_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_ready;
	logic             start_frame;
	logic [SYM_W-1:0] symbol;
	logic             out_valid;
	logic             out_ready;
	logic             placed;
	logic [OUT_W-1:0] cell_row;
	logic [OUT_W-1:0] cell_col;
	logic [SYM_W-1:0] cell_symbol;

	placement_checker checker_h;
	bit quiet;
	bit hold_request;
	int requests_sent;
	int grid_settings;
	int idle_cycles;

	serpentine_cell_placer_top #(
		.MAX_DIM(GRID_MAX)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.start_frame(start_frame),
		.symbol     (symbol),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.placed     (placed),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.cell_symbol(cell_symbol)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(99);
		if (roll < 70)
			return 0;
		if (roll < 93)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	task automatic send_request(input logic sf, input logic [SYM_W-1:0] sym);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		start_frame <= sf;
		symbol <= sym;
		do @(posedge clk); while (!in_ready);
		checker_h.note_request(sf, sym);
		requests_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (checker_h.expected_cells.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_grid(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
		cfg_valid <= 1'b1;
		cfg_index <= REG_GRID_ROWS;
		cfg_data <= rows;
		do @(posedge clk); while (!cfg_ready);
		checker_h.write_reg(REG_GRID_ROWS, rows);
		cfg_index <= REG_GRID_COLS;
		cfg_data <= cols;
		do @(posedge clk); while (!cfg_ready);
		checker_h.write_reg(REG_GRID_COLS, cols);
		cfg_valid <= 1'b0;
		grid_settings++;
	endtask

	initial begin : receiver
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				checker_h.check_result(cell_result_t'{placed, cell_row, cell_col, cell_symbol});
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				stall_left = pick_gap();
				out_ready <= (stall_left == 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int phase;
		int len;
		int roll;
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
		logic sf;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_GRID_ROWS;
		cfg_data = '0;
		in_valid = 1'b0;
		start_frame = 1'b0;
		symbol = '0;
		quiet = 1'b0;
		hold_request = 1'b0;
		requests_sent = 0;
		grid_settings = 0;
		idle_cycles = 0;
		checker_h = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset grid: every symbol value, with a restart in the middle of the frame.
		send_request(1'b0, 2'd0);
		send_request(1'b0, 2'd1);
		send_request(1'b0, 2'd2);
		send_request(1'b1, 2'd3);
		send_request(1'b0, 2'd3);
		drain();
		// An empty grid is always full.
		set_grid(9'd0, 9'd0);
		send_request(1'b1, 2'd1);
		send_request(1'b0, 2'd2);
		drain();
		// Sizes past the maximum saturate.
		set_grid(9'd511, 9'd511);
		send_request(1'b1, 2'd0);
		send_request(1'b0, 2'd3);
		send_request(1'b0, 2'd1);
		drain();
		// Top rows with no free cell at all.
		set_grid(9'd17, 9'd16);
		send_request(1'b1, 2'd2);
		send_request(1'b0, 2'd1);
		send_request(1'b0, 2'd0);
		drain();
		// Grid grows while the frame is under way.
		set_grid(9'd256, 9'd256);
		send_request(1'b0, 2'd3);
		send_request(1'b0, 2'd2);
		drain();
		set_grid(9'd257, 9'd17);
		send_request(1'b1, 2'd1);
		send_request(1'b0, 2'd0);

		phase = 0;
		while (requests_sent < TARGET_ITEMS) begin
			phase++;
			roll = $urandom_range(99);
			if (roll < 55) begin
				rows = DIM_W'($urandom_range(30, 17));
				cols = DIM_W'($urandom_range(30, 17));
			end else if (roll < 70) begin
				rows = DIM_W'($urandom_range(20));
				cols = DIM_W'($urandom_range(20));
			end else if (roll < 88) begin
				rows = DIM_W'($urandom_range(120, 40));
				cols = DIM_W'($urandom_range(200, 40));
			end else begin
				rows = DIM_W'($urandom_range(511));
				cols = DIM_W'($urandom_range(511));
			end
			drain();
			set_grid(rows, cols);
			quiet = ($urandom_range(4) == 0);
			if (phase == 3)
				hold_request = 1'b1;
			len = $urandom_range(120, 40);
			for (int i = 0; i < len; i++) begin
				if (i == 0)
					sf = ($urandom_range(3) != 0);
				else
					sf = ($urandom_range(149) == 0);
				send_request(sf, SYM_W'($urandom_range(3)));
			end
		end
		drain();
		repeat (20) @(posedge clk);

		if (checker_h.expected_cells.size() != 0) begin
			$display("%0d results never arrived", checker_h.expected_cells.size());
			checker_h.mismatches++;
		end
		$display("Sent %0d requests across %0d grid sizes.", requests_sent, grid_settings);
		$display("Results: %0d cells placed, %0d grid-full, %0d mismatches.",
			checker_h.placed_seen, checker_h.full_seen, checker_h.mismatches);
		if (checker_h.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
